[sv/sre_pkg.sv]
`timescale 1ns / 1ps

package sre_pkg;

   // result slots in the output queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;

   // results that one processed index pushes into the queue, in order
   typedef struct packed {
      logic one;   // at least one range ready
      logic two;   // a broken range and the final single both ready
   } push_type;

endpackage

[sv/sre_core.sv]
`timescale 1ns / 1ps

module sre_core
   import sre_pkg::*;
#(
   parameter int INDEX_BITS = 32,
   localparam int RANGE_BITS = 4 * INDEX_BITS + 3
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic [INDEX_BITS-1:0] index,
   input  logic                  is_last,
   output push_type              push,
   output logic [RANGE_BITS-1:0] range0,
   output logic [RANGE_BITS-1:0] range1
);

   localparam int EW = INDEX_BITS + 1;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_SINGLE = 3'b010,
      PH_STRIDE = 3'b100
   } phase_type;

   phase_type             phase_ff, phase_in, mid_phase;
   logic [INDEX_BITS-1:0] open_begin_ff, mid_begin;
   logic [INDEX_BITS-1:0] open_last_ff, mid_last;
   logic [INDEX_BITS-1:0] open_step_ff, mid_step;
   logic [EW-1:0]         open_members_ff, mid_members;
   logic [INDEX_BITS-1:0] diff_last, diff_begin;
   logic                  brk;
   logic [RANGE_BITS-1:0] brk_range, fin_range;

   // packed range: begin lowest, then end, step, members, final flag
   function automatic logic [RANGE_BITS-1:0] pack_range(
      input logic                  stride,
      input logic [INDEX_BITS-1:0] b,
      input logic [INDEX_BITS-1:0] l,
      input logic [INDEX_BITS-1:0] s,
      input logic [EW-1:0]         m,
      input logic                  fin
   );
      logic [EW-1:0]         e;
      logic [INDEX_BITS-1:0] st;
      e  = {1'b0, l} + EW'(1);
      st = stride ? s : INDEX_BITS'(1);
      return {fin, m, st, e, b};
   endfunction

   assign diff_last  = index - open_last_ff;
   assign diff_begin = index - open_begin_ff;

   always_comb begin
      mid_phase   = phase_ff;
      mid_begin   = open_begin_ff;
      mid_last    = open_last_ff;
      mid_step    = open_step_ff;
      mid_members = open_members_ff;
      brk         = 1'b0;
      unique case (phase_ff)
         PH_SINGLE: begin
            if (index != open_last_ff) begin
               mid_phase   = PH_STRIDE;
               mid_step    = diff_begin;
               mid_last    = index;
               mid_members = EW'(2);
            end
         end
         PH_STRIDE: begin
            if (index == open_last_ff) begin
               // repeated index, dropped
               mid_phase = PH_STRIDE;
            end else if (diff_last == open_step_ff) begin
               mid_last = index;
               if (open_members_ff != {EW{1'b1}}) begin
                  mid_members = open_members_ff + EW'(1);
               end
            end else begin
               brk         = 1'b1;
               mid_phase   = PH_SINGLE;
               mid_begin   = index;
               mid_last    = index;
               mid_members = EW'(1);
            end
         end
         default: begin
            mid_phase   = PH_SINGLE;
            mid_begin   = index;
            mid_last    = index;
            mid_members = EW'(1);
         end
      endcase
      phase_in = is_last ? PH_IDLE : mid_phase;
   end

   assign brk_range = pack_range(phase_ff == PH_STRIDE, open_begin_ff, open_last_ff,
                                 open_step_ff, open_members_ff, 1'b0);
   assign fin_range = pack_range(mid_phase == PH_STRIDE, mid_begin, mid_last,
                                 mid_step, mid_members, 1'b1);

   assign push.one = step_en & (brk | is_last);
   assign push.two = step_en & brk & is_last;
   assign range0   = brk ? brk_range : fin_range;
   assign range1   = fin_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else if (step_en) begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         open_begin_ff   <= mid_begin;
         open_last_ff    <= mid_last;
         open_step_ff    <= mid_step;
         open_members_ff <= mid_members;
      end
   end

endmodule

[sv/sre_out_queue.sv]
`timescale 1ns / 1ps

module sre_out_queue
   import sre_pkg::*;
#(
   parameter int RANGE_BITS = 131
) (
   input  logic                  clock,
   input  logic                  reset,
   input  push_type              push,
   input  logic [RANGE_BITS-1:0] range0,
   input  logic [RANGE_BITS-1:0] range1,
   output logic                  room,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [RANGE_BITS-1:0] out_range
);

   localparam int CW = QPTR_BITS + 1;

   logic [RANGE_BITS-1:0] slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  pop;

   assign out_valid = (count_ff != '0);
   assign out_range = slot_ff[rd_ptr_ff];
   assign pop       = out_valid & out_ready;
   // two free slots, so a break on the final index always fits
   assign room      = (count_ff <= CW'(QUEUE_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + QPTR_BITS'(push.one) + QPTR_BITS'(push.two);
   assign rd_ptr_in = rd_ptr_ff + QPTR_BITS'(pop);
   assign count_in  = count_ff + CW'(push.one) + CW'(push.two) - CW'(pop);

   always_ff @(posedge clock) begin
      if (push.one) begin
         slot_ff[wr_ptr_ff] <= range0;
      end
      if (push.two) begin
         slot_ff[wr_ptr_ff + QPTR_BITS'(1)] <= range1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[sv/stride_range_encoder.sv]
`timescale 1ns / 1ps

// stride range encoder
// req channel: one sorted index per transfer in req_tdata, req_tlast on the
// final index of a set. repeated indices are dropped; distinct ones are packed
// into arithmetic ranges (begin, exclusive end, step, member count).
// rsp channel: one range per transfer, rsp_tlast on the final range of a set.
// a set ends after the req transfer with req_tlast; the next index opens a new set.
// path: a range caused by an index passes the input register, then the result
// queue, before its rsp transfer.
// throughput: one index per cycle; an index yields zero, one or two ranges,
// and the four-slot result queue drains one range per cycle while rsp_tready
// is high. the input register moves on only while two queue slots are free,
// so req_tready drops when the rsp side stalls until fewer than two are free.
// reset: synchronous, clears the open range and empties the queue.
module stride_range_encoder
   import sre_pkg::*;
#(
   parameter int INDEX_BITS = 32,
   localparam int IN_DATA_BITS  = ((INDEX_BITS + 7) / 8) * 8,
   localparam int OUT_DATA_BITS = ((4 * INDEX_BITS + 2 + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [IN_DATA_BITS-1:0]  req_tdata,   // index
   input  logic                     req_tlast,   // is_last
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [OUT_DATA_BITS-1:0] rsp_tdata,   // range_begin, range_end,
                                                 // range_step, range_members
   output logic                     rsp_tlast    // run_last
);

   localparam int RANGE_BITS = 4 * INDEX_BITS + 3;
   localparam int DATA_BITS  = 4 * INDEX_BITS + 2;

   logic                  in_valid_ff, in_valid_in;
   logic [INDEX_BITS-1:0] in_index_ff;
   logic                  in_last_ff;
   logic                  room, step_en, req_take;
   push_type              push;
   logic [RANGE_BITS-1:0] range0, range1, out_range;

   assign step_en    = in_valid_ff & room;
   assign req_tready = ~in_valid_ff | room;
   assign req_take   = req_tvalid & req_tready;
   assign in_valid_in = req_take | (in_valid_ff & ~room);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_index_ff <= req_tdata[INDEX_BITS-1:0];
         in_last_ff  <= req_tlast;
      end
   end

   sre_core #(
      .INDEX_BITS (INDEX_BITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .index   (in_index_ff),
      .is_last (in_last_ff),
      .push    (push),
      .range0  (range0),
      .range1  (range1)
   );

   sre_out_queue #(
      .RANGE_BITS (RANGE_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .range0    (range0),
      .range1    (range1),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_range (out_range)
   );

   assign rsp_tdata = OUT_DATA_BITS'(out_range[DATA_BITS-1:0]);
   assign rsp_tlast = out_range[RANGE_BITS-1];

   // a second range only comes with a final index
   a_two_needs_last: assert property (@(posedge clock) disable iff (reset)
      push.two |-> (push.one && in_last_ff))
      else $error("second range pushed without a final index");

   // every push comes from an item processed with queue room
   a_push_needs_room: assert property (@(posedge clock) disable iff (reset)
      push.one |-> (in_valid_ff && room))
      else $error("range pushed without a processed index");

   // a held input item keeps its payload
   a_hold_stage: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !room) |=> (in_valid_ff && $stable(in_index_ff)
                                  && $stable(in_last_ff)))
      else $error("input register lost a stalled index");

   // a req transfer always lands in the input register
   a_take_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> in_valid_ff)
      else $error("accepted index not captured");

endmodule
